>>> hdl/pwmpg_pkg.sv
// ============================================================================
// PWM pattern generator package
// Shared widths, register indexes, mode codes, reset values and the
// controller state and command types.
// ============================================================================
package pwmpg_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int TIME_WIDTH_DEF       = 24;

    localparam int MODE_W      = 3;
    localparam int AMP_W       = 8;
    localparam int DUTY_W      = 8;
    localparam int PHASE_W     = 32;
    localparam int SINE_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_COUNT_W = $clog2(DUTY_W);

    localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_PERIOD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_TIME   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_TIME    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_STOP     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SINE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONSTANT = 3'd4;

    localparam logic [AMP_W-1:0]   AMPLITUDE_RESET  = 8'd180;
    localparam int                 RAMP_RESET       = 1000;
    localparam int                 HIGH_RESET       = 500;
    localparam int                 LOW_RESET        = 500;
    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd1073742;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SETUP,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic prepare;
        logic setup;
        logic div_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ctrl_status_t;

endpackage

>>> hdl/pwm_pattern_generator.sv
// ============================================================================
// PWM pattern generator
// One duty value per millisecond tick: stop, sawtooth, square, sine or
// constant pattern, selected and shaped by the configuration registers.
// ============================================================================
// A tick is accepted in idle and runs the load, setup, divide (8-step
// restoring divider for the sawtooth) and emit steps, and emit puts its duty
// on m_tvalid. Emit waits while the output is stalled; the next tick is taken
// only after emit, and is computed while the output register still holds a result.
// Reset: synchronous on aresetn; registers take their defaults, position and
// phase clear to zero, and there is no clearing pass.
module pwm_pattern_generator #(
    parameter int SINE_TABLE_DEPTH = pwmpg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int TIME_WIDTH       = pwmpg_pkg::TIME_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [0] restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] duty
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pwmpg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pwmpg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pwmpg_pkg::ctrl_cmd_t          cmd;
    pwmpg_pkg::ctrl_status_t       status;
    logic [pwmpg_pkg::MODE_W-1:0]  mode;
    logic [pwmpg_pkg::AMP_W-1:0]   amplitude;
    logic [TIME_WIDTH-1:0]         ramp_period;
    logic [TIME_WIDTH-1:0]         high_time;
    logic [TIME_WIDTH-1:0]         low_time;
    logic [pwmpg_pkg::PHASE_W-1:0] phase_step;
    logic [pwmpg_pkg::DUTY_W-1:0]  duty;

    assign cfg_ready = 1'b1;

    pwmpg_cfg_regs #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_cfg_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .amplitude  (amplitude),
        .ramp_period(ramp_period),
        .high_time  (high_time),
        .low_time   (low_time),
        .phase_step (phase_step)
    );

    pwmpg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    pwmpg_datapath #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
        .TIME_WIDTH      (TIME_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .restart    (s_tdata[0]),
        .mode       (mode),
        .amplitude  (amplitude),
        .ramp_period(ramp_period),
        .high_time  (high_time),
        .low_time   (low_time),
        .phase_step (phase_step),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .duty       (duty)
    );

    assign m_tdata = duty;

endmodule

>>> hdl/pwmpg_cfg_regs.sv
// ============================================================================
// PWM pattern generator configuration registers
// Holds the pattern settings written through the configuration channel.
// ============================================================================
module pwmpg_cfg_regs #(
    parameter int TIME_WIDTH = pwmpg_pkg::TIME_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [pwmpg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pwmpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [pwmpg_pkg::MODE_W-1:0]       mode,
    output logic [pwmpg_pkg::AMP_W-1:0]        amplitude,
    output logic [TIME_WIDTH-1:0]              ramp_period,
    output logic [TIME_WIDTH-1:0]              high_time,
    output logic [TIME_WIDTH-1:0]              low_time,
    output logic [pwmpg_pkg::PHASE_W-1:0]      phase_step
);

    logic [pwmpg_pkg::MODE_W-1:0]  mode_reg;
    logic [pwmpg_pkg::AMP_W-1:0]   amplitude_reg;
    logic [TIME_WIDTH-1:0]         ramp_reg;
    logic [TIME_WIDTH-1:0]         high_reg;
    logic [TIME_WIDTH-1:0]         low_reg;
    logic [pwmpg_pkg::PHASE_W-1:0] phase_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= pwmpg_pkg::MODE_STOP;
            amplitude_reg  <= pwmpg_pkg::AMPLITUDE_RESET;
            ramp_reg       <= TIME_WIDTH'(pwmpg_pkg::RAMP_RESET);
            high_reg       <= TIME_WIDTH'(pwmpg_pkg::HIGH_RESET);
            low_reg        <= TIME_WIDTH'(pwmpg_pkg::LOW_RESET);
            phase_step_reg <= pwmpg_pkg::PHASE_STEP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                pwmpg_pkg::REG_MODE: begin
                    mode_reg <= cfg_data[pwmpg_pkg::MODE_W-1:0];
                end
                pwmpg_pkg::REG_AMPLITUDE: begin
                    amplitude_reg <= cfg_data[pwmpg_pkg::AMP_W-1:0];
                end
                pwmpg_pkg::REG_RAMP_PERIOD: begin
                    ramp_reg <= cfg_data[TIME_WIDTH-1:0];
                end
                pwmpg_pkg::REG_HIGH_TIME: begin
                    high_reg <= cfg_data[TIME_WIDTH-1:0];
                end
                pwmpg_pkg::REG_LOW_TIME: begin
                    low_reg <= cfg_data[TIME_WIDTH-1:0];
                end
                pwmpg_pkg::REG_PHASE_STEP: begin
                    phase_step_reg <= cfg_data[pwmpg_pkg::PHASE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign mode        = mode_reg;
    assign amplitude   = amplitude_reg;
    assign ramp_period = ramp_reg;
    assign high_time   = high_reg;
    assign low_time    = low_reg;
    assign phase_step  = phase_step_reg;

endmodule

>>> hdl/pwmpg_sine_rom.sv
// ============================================================================
// PWM pattern generator sine table
// Constant Q1.15 sine table built at elaboration, with a registered read.
// ============================================================================
module pwmpg_sine_rom #(
    parameter int SINE_TABLE_DEPTH = pwmpg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  rd_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]   rd_addr,
    output logic signed [pwmpg_pkg::SINE_W-1:0]   rd_data
);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Taylor series in Q2.30 for 0 <= x <= pi/4.
    function automatic logic [63:0] series_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    function automatic logic [63:0] series_cos(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd90;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd56;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd12;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd2;
        return t;
    endfunction

    function automatic logic signed [pwmpg_pkg::SINE_W-1:0] sine_entry(input int k);
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] s_phi;
        logic [63:0] c_phi;
        logic [63:0] mag;
        logic [63:0] q15;
        logic signed [pwmpg_pkg::SINE_W-1:0] val;
        quad = (64'(4 * k)) / 64'(SINE_TABLE_DEPTH);
        r    = 64'(4 * k) - quad * 64'(SINE_TABLE_DEPTH);
        if (2 * r <= 64'(SINE_TABLE_DEPTH)) begin
            x     = (HALF_PI_Q30 * r) / 64'(SINE_TABLE_DEPTH);
            s_phi = series_sin(x);
            c_phi = series_cos(x);
        end else begin
            x     = (HALF_PI_Q30 * (64'(SINE_TABLE_DEPTH) - r)) / 64'(SINE_TABLE_DEPTH);
            s_phi = series_cos(x);
            c_phi = series_sin(x);
        end
        mag = quad[0] ? c_phi : s_phi;
        if (mag > ONE_Q30) begin
            mag = ONE_Q30;
        end
        q15 = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
        val = pwmpg_pkg::SINE_W'(q15);
        return (quad >= 64'd2) ? -val : val;
    endfunction

    logic signed [pwmpg_pkg::SINE_W-1:0] sine_table [SINE_TABLE_DEPTH];
    logic signed [pwmpg_pkg::SINE_W-1:0] rd_data_reg;

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
        assign sine_table[k] = sine_entry(k);
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= sine_table[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/pwmpg_datapath.sv
// ============================================================================
// PWM pattern generator datapath
// Pattern position and sine phase state, sawtooth divider, sine scaling,
// duty selection and the output register.
// ============================================================================
module pwmpg_datapath #(
    parameter int SINE_TABLE_DEPTH = pwmpg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int TIME_WIDTH       = pwmpg_pkg::TIME_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pwmpg_pkg::ctrl_cmd_t            cmd,
    output pwmpg_pkg::ctrl_status_t         status,
    input  logic                            restart,
    input  logic [pwmpg_pkg::MODE_W-1:0]    mode,
    input  logic [pwmpg_pkg::AMP_W-1:0]     amplitude,
    input  logic [TIME_WIDTH-1:0]           ramp_period,
    input  logic [TIME_WIDTH-1:0]           high_time,
    input  logic [TIME_WIDTH-1:0]           low_time,
    input  logic [pwmpg_pkg::PHASE_W-1:0]   phase_step,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pwmpg_pkg::DUTY_W-1:0]    duty
);

    localparam int POS_W   = TIME_WIDTH + 1;
    localparam int REM_W   = TIME_WIDTH + pwmpg_pkg::DUTY_W + 1;
    localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IDX_W   = pwmpg_pkg::PHASE_W + DEPTH_W;
    localparam int SPROD_W = pwmpg_pkg::AMP_W + pwmpg_pkg::SINE_W;

    logic [POS_W-1:0]              position_count_reg;
    logic [pwmpg_pkg::PHASE_W-1:0] sine_phase_reg;
    logic                          restart_reg;
    logic [POS_W-1:0]              pos_cur_reg;
    logic [pwmpg_pkg::PHASE_W-1:0] phase_cur_reg;
    logic [POS_W-1:0]              period_reg;
    logic                          has_period_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [REM_W-1:0]              dsor_reg;
    logic [pwmpg_pkg::DUTY_W-1:0]  quot_reg;
    logic [pwmpg_pkg::DUTY_W-1:0]  sine_duty_reg;
    logic [pwmpg_pkg::DUTY_W-1:0]  duty_reg;
    logic                          m_tvalid_reg;

    logic [POS_W-1:0]              pos_eff;
    logic [pwmpg_pkg::PHASE_W-1:0] phase_eff;
    logic [POS_W-1:0]              period;
    logic                          has_period;
    logic [POS_W-1:0]              pos_cur_next;
    logic [IDX_W-1:0]              idx_prod;
    logic [ADDR_W-1:0]             rom_addr;
    logic signed [pwmpg_pkg::SINE_W-1:0] sine_data;
    logic [pwmpg_pkg::SINE_W-1:0]  sine_offset;
    logic [SPROD_W-1:0]            sine_prod;
    logic [REM_W-1:0]              saw_prod;
    logic [REM_W-1:0]              numerator;
    logic [POS_W-1:0]              pos_inc;
    logic [POS_W-1:0]              position_count_next;
    logic [REM_W-1:0]              rem_diff;
    logic                          rem_ge;
    logic [pwmpg_pkg::DUTY_W-1:0]  duty_next;

    always_comb begin
        pos_eff   = restart_reg ? '0 : position_count_reg;
        phase_eff = restart_reg ? '0 : sine_phase_reg;
        case (mode)
            pwmpg_pkg::MODE_SAWTOOTH: begin
                period     = POS_W'(ramp_period);
                has_period = 1'b1;
            end
            pwmpg_pkg::MODE_SQUARE: begin
                period     = POS_W'(high_time) + POS_W'(low_time);
                has_period = 1'b1;
            end
            default: begin
                period     = '0;
                has_period = 1'b0;
            end
        endcase
        pos_cur_next = (has_period && (pos_eff >= period)) ? '0 : pos_eff;
        idx_prod     = IDX_W'(phase_eff) * IDX_W'(SINE_TABLE_DEPTH);
        rom_addr     = idx_prod[pwmpg_pkg::PHASE_W +: ADDR_W];
    end

    pwmpg_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .aclk   (aclk),
        .rd_en  (cmd.prepare),
        .rd_addr(rom_addr),
        .rd_data(sine_data)
    );

    always_comb begin
        // Adding 32768 to a Q1.15 value in range is a flip of its sign bit.
        sine_offset = {~sine_data[pwmpg_pkg::SINE_W-1], sine_data[pwmpg_pkg::SINE_W-2:0]};
        sine_prod   = SPROD_W'(amplitude) * SPROD_W'(sine_offset)
                    + SPROD_W'(32768);
        saw_prod    = REM_W'(amplitude) * REM_W'(pos_cur_reg);
        numerator   = {saw_prod[REM_W-2:0], 1'b0} + REM_W'(ramp_period);
        pos_inc     = pos_cur_reg + POS_W'(1);
        if (has_period_reg) begin
            position_count_next = (pos_inc >= period_reg) ? '0 : pos_inc;
        end else begin
            position_count_next = pos_inc;
        end
        rem_ge   = (rem_reg >= dsor_reg);
        rem_diff = rem_reg - dsor_reg;
        case (mode)
            pwmpg_pkg::MODE_SAWTOOTH: begin
                duty_next = (ramp_period == '0) ? amplitude : quot_reg;
            end
            pwmpg_pkg::MODE_SQUARE: begin
                duty_next = (pos_cur_reg < POS_W'(high_time)) ? amplitude : '0;
            end
            pwmpg_pkg::MODE_SINE: begin
                duty_next = sine_duty_reg;
            end
            pwmpg_pkg::MODE_CONSTANT: begin
                duty_next = amplitude;
            end
            default: begin
                duty_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_count_reg <= '0;
            sine_phase_reg     <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cmd.setup) begin
                position_count_reg <= position_count_next;
                sine_phase_reg     <= phase_cur_reg + phase_step;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            restart_reg <= restart;
        end
        if (cmd.prepare) begin
            pos_cur_reg    <= pos_cur_next;
            phase_cur_reg  <= phase_eff;
            period_reg     <= period;
            has_period_reg <= has_period;
        end
        if (cmd.setup) begin
            rem_reg       <= numerator;
            dsor_reg      <= REM_W'(ramp_period) << (pwmpg_pkg::DUTY_W);
            quot_reg      <= '0;
            sine_duty_reg <= sine_prod[SPROD_W-1 -: pwmpg_pkg::DUTY_W];
        end
        if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= rem_diff;
            end
            quot_reg <= {quot_reg[pwmpg_pkg::DUTY_W-2:0], rem_ge};
            dsor_reg <= dsor_reg >> 1;
        end
        if (cmd.emit) begin
            duty_reg <= duty_next;
        end
    end

    // The divisor is loaded as ramp * 2^8, which is (2 * ramp) * 2^7 for the
    // first quotient bit.
    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign duty            = duty_reg;

endmodule

>>> hdl/pwmpg_ctrl.sv
// ============================================================================
// PWM pattern generator controller
// Sequences one tick through load, setup, divide and emit steps.
// ============================================================================
module pwmpg_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  pwmpg_pkg::ctrl_status_t  status,
    output pwmpg_pkg::ctrl_cmd_t     cmd
);

    pwmpg_pkg::state_t                   state_reg;
    pwmpg_pkg::state_t                   state_next;
    logic [pwmpg_pkg::DIV_COUNT_W-1:0]   count_reg;
    logic [pwmpg_pkg::DIV_COUNT_W-1:0]   count_next;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            pwmpg_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = pwmpg_pkg::ST_LOAD;
                end
            end
            pwmpg_pkg::ST_LOAD: begin
                state_next = pwmpg_pkg::ST_SETUP;
            end
            pwmpg_pkg::ST_SETUP: begin
                state_next = pwmpg_pkg::ST_DIVIDE;
                count_next = pwmpg_pkg::DIV_COUNT_W'(pwmpg_pkg::DUTY_W - 1);
            end
            pwmpg_pkg::ST_DIVIDE: begin
                count_next = count_reg - pwmpg_pkg::DIV_COUNT_W'(1);
                if (count_reg == '0) begin
                    state_next = pwmpg_pkg::ST_EMIT;
                end
            end
            pwmpg_pkg::ST_EMIT: begin
                if (!status.out_busy) begin
                    state_next = pwmpg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pwmpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            pwmpg_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            pwmpg_pkg::ST_LOAD: begin
                cmd.prepare = 1'b1;
            end
            pwmpg_pkg::ST_SETUP: begin
                cmd.setup = 1'b1;
            end
            pwmpg_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            pwmpg_pkg::ST_EMIT: begin
                cmd.emit = !status.out_busy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pwmpg_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> tb/tb_pwm_pattern_generator.sv
// ============================================================================
// PWM pattern generator testbench
// Drives millisecond tick transactions and register writes into the pattern
// generator with random gaps and output stalls. A scoreboard class keeps its
// own copy of the registers, the position counter, the sine phase and the
// sine table. It predicts one duty per accepted tick and compares each duty
// transaction with the oldest prediction.
// ============================================================================
module tb_pwm_pattern_generator;
    import pwmpg_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [MODE_W-1:0]      MODE_UNKNOWN_LO = 3'd5;
    localparam logic [MODE_W-1:0]      MODE_UNKNOWN_HI = 3'd7;
    localparam longint unsigned        HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned        ONE_Q30     = 64'd1073741824;

    class duty_scoreboard;
        logic [MODE_W-1:0]         mode;
        logic [AMP_W-1:0]          amplitude;
        logic [TIME_WIDTH_DEF-1:0] ramp_period;
        logic [TIME_WIDTH_DEF-1:0] high_time;
        logic [TIME_WIDTH_DEF-1:0] low_time;
        logic [PHASE_W-1:0]        phase_step;
        logic [TIME_WIDTH_DEF:0]   position;
        logic [PHASE_W-1:0]        phase;
        int                        sine_tab[SINE_TABLE_DEPTH_DEF];
        logic [DUTY_W-1:0]         pending_duty[$];
        int                        errors;

        function automatic longint unsigned series_sin(longint unsigned x);
            longint unsigned x2;
            longint unsigned t;
            x2 = (x * x) >> 30;
            t = ONE_Q30 - x2 / 72;
            t = ONE_Q30 - ((x2 * t) >> 30) / 42;
            t = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t = ONE_Q30 - ((x2 * t) >> 30) / 6;
            return (x * t) >> 30;
        endfunction

        function automatic longint unsigned series_cos(longint unsigned x);
            longint unsigned x2;
            longint unsigned t;
            x2 = (x * x) >> 30;
            t = ONE_Q30 - x2 / 90;
            t = ONE_Q30 - ((x2 * t) >> 30) / 56;
            t = ONE_Q30 - ((x2 * t) >> 30) / 30;
            t = ONE_Q30 - ((x2 * t) >> 30) / 12;
            t = ONE_Q30 - ((x2 * t) >> 30) / 2;
            return t;
        endfunction

        function new();
            longint unsigned depth;
            longint unsigned quad;
            longint unsigned r;
            longint unsigned x;
            longint unsigned s_val;
            longint unsigned c_val;
            longint unsigned mag;
            longint unsigned q15;
            depth       = SINE_TABLE_DEPTH_DEF;
            mode        = MODE_STOP;
            amplitude   = AMPLITUDE_RESET;
            ramp_period = TIME_WIDTH_DEF'(RAMP_RESET);
            high_time   = TIME_WIDTH_DEF'(HIGH_RESET);
            low_time    = TIME_WIDTH_DEF'(LOW_RESET);
            phase_step  = PHASE_STEP_RESET;
            position    = '0;
            phase       = '0;
            errors      = 0;
            for (int k = 0; k < SINE_TABLE_DEPTH_DEF; k++) begin
                quad = (4 * longint'(k)) / depth;
                r = 4 * longint'(k) - quad * depth;
                if (2 * r <= depth) begin
                    x = (HALF_PI_Q30 * r) / depth;
                    s_val = series_sin(x);
                    c_val = series_cos(x);
                end else begin
                    x = (HALF_PI_Q30 * (depth - r)) / depth;
                    s_val = series_cos(x);
                    c_val = series_sin(x);
                end
                mag = quad[0] ? c_val : s_val;
                if (mag > ONE_Q30) mag = ONE_Q30;
                q15 = (mag * 32767 + (64'd1 << 29)) >> 30;
                sine_tab[k] = (quad >= 2) ? -int'(q15) : int'(q15);
            end
        endfunction

        function void config_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_MODE:        mode        = data[MODE_W-1:0];
                REG_AMPLITUDE:   amplitude   = data[AMP_W-1:0];
                REG_RAMP_PERIOD: ramp_period = data[TIME_WIDTH_DEF-1:0];
                REG_HIGH_TIME:   high_time   = data[TIME_WIDTH_DEF-1:0];
                REG_LOW_TIME:    low_time    = data[TIME_WIDTH_DEF-1:0];
                REG_PHASE_STEP:  phase_step  = data;
                default: ;
            endcase
        endfunction

        function void note_tick(bit restart);
            longint unsigned period;
            longint unsigned pos;
            longint unsigned duty;
            longint unsigned idx;
            longint unsigned amp;
            bit              has_period;
            period     = 0;
            has_period = 1'b0;
            duty       = 0;
            amp        = 64'(amplitude);
            if (restart) begin
                position = '0;
                phase    = '0;
            end
            if (mode == MODE_SAWTOOTH) begin
                period     = 64'(ramp_period);
                has_period = 1'b1;
            end else if (mode == MODE_SQUARE) begin
                period     = longint'(high_time) + longint'(low_time);
                has_period = 1'b1;
            end
            if (has_period && longint'(position) >= period) position = '0;
            pos = 64'(position);
            case (mode)
                MODE_SAWTOOTH: begin
                    if (period == 0) duty = amp;
                    else duty = (2 * amp * pos + period) / (2 * period);
                end
                MODE_SQUARE:   duty = (pos < longint'(high_time)) ? amp : 0;
                MODE_SINE: begin
                    idx  = (longint'(phase) * SINE_TABLE_DEPTH_DEF) >> 32;
                    duty = (amp * longint'(32768 + sine_tab[idx % SINE_TABLE_DEPTH_DEF])
                            + 32768) >> 16;
                end
                MODE_CONSTANT: duty = amp;
                default:       duty = 0;
            endcase
            if (duty > 255) duty = 255;
            if (has_period) begin
                position = (pos + 1 >= period) ? '0 : (TIME_WIDTH_DEF + 1)'(pos + 1);
            end else begin
                position = (TIME_WIDTH_DEF + 1)'(pos + 1);
            end
            phase = phase + phase_step;
            pending_duty.push_back(duty[DUTY_W-1:0]);
        endfunction

        function void check_duty(logic [DUTY_W-1:0] got);
            logic [DUTY_W-1:0] want;
            if (pending_duty.size() == 0) begin
                $display("%0t: duty transaction with none expected, expected none, actual %0d",
                         $time, got);
                errors++;
            end else begin
                want = pending_duty.pop_front();
                if (want !== got) begin
                    $display("%0t: duty mismatch, expected %0d, actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_duty.size();
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'd0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    duty_scoreboard sb = new();
    bit             steady = 1'b0;

    pwm_pattern_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_time();
        int                        r;
        logic [TIME_WIDTH_DEF-1:0] v;
        logic [CFG_DATA_W-1:0]     hi;
        r  = $urandom_range(0, 19);
        hi = $urandom;
        if (r == 0) v = '0;
        else if (r == 1) v = '1;
        else if (r == 2) v = TIME_WIDTH_DEF'($urandom);
        else if (r < 14) v = TIME_WIDTH_DEF'($urandom_range(1, 12));
        else v = TIME_WIDTH_DEF'($urandom_range(13, 400));
        return {hi[CFG_DATA_W-1:TIME_WIDTH_DEF], v};
    endfunction

    task automatic send_tick(input bit restart);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(restart);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.config_write(index, data);
        cfg_valid <= 1'b0;
        repeat (gap_len() + 1) @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_duty(m_tdata);
    end

    initial begin
        int len;
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            len = $urandom_range(1, 12);
            repeat (len) @(posedge aclk);
            len = gap_len();
            if (len > 0) begin
                m_tready <= 1'b0;
                repeat (len) @(posedge aclk);
            end
        end
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int                    random_ticks;
        int                    r;
        int                    n;
        logic [CFG_DATA_W-1:0] hi;
        logic [MODE_W-1:0]     mode_code;
        logic [AMP_W-1:0]      amp;
        logic [PHASE_W-1:0]    step;
        random_ticks = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset state: stop mode, then a restart.
        send_tick(1'b0);
        send_tick(1'b1);

        settle();
        write_reg(REG_MODE, {29'd0, MODE_CONSTANT});
        write_reg(REG_AMPLITUDE, 32'd255);
        send_tick(1'b0);
        settle();
        write_reg(REG_AMPLITUDE, 32'd0);
        send_tick(1'b1);

        // Sawtooth with a wrap, a restart, a shrunk period and a zero period.
        settle();
        write_reg(REG_MODE, {29'd0, MODE_SAWTOOTH});
        write_reg(REG_AMPLITUDE, 32'd255);
        write_reg(REG_RAMP_PERIOD, 32'd4);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();
        write_reg(REG_RAMP_PERIOD, 32'd2);
        send_tick(1'b0);
        settle();
        write_reg(REG_RAMP_PERIOD, 32'd0);
        send_tick(1'b0);

        // Square with a full period, a zero period and a zero high time.
        settle();
        write_reg(REG_MODE, {29'd0, MODE_SQUARE});
        write_reg(REG_AMPLITUDE, 32'd200);
        write_reg(REG_HIGH_TIME, 32'd2);
        write_reg(REG_LOW_TIME, 32'd1);
        repeat (4) send_tick(1'b0);
        settle();
        write_reg(REG_HIGH_TIME, 32'd0);
        write_reg(REG_LOW_TIME, 32'd0);
        send_tick(1'b0);
        settle();
        write_reg(REG_LOW_TIME, 32'd3);
        send_tick(1'b0);

        // Sine in quarter cycles, then the largest phase step.
        settle();
        write_reg(REG_MODE, {29'd0, MODE_SINE});
        write_reg(REG_AMPLITUDE, 32'd255);
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        send_tick(1'b0);

        // Unknown modes and writes to indexes past the register list.
        settle();
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0001);
        write_reg(REG_MODE, {29'd0, MODE_UNKNOWN_LO});
        send_tick(1'b0);
        settle();
        write_reg(REG_MODE, {29'd0, MODE_UNKNOWN_HI});
        send_tick(1'b0);

        while (random_ticks < 1400) begin
            settle();
            steady = ($urandom_range(0, 4) == 0);
            hi = $urandom;
            r = $urandom_range(0, 9);
            mode_code = (r < 8) ? MODE_W'($urandom_range(1, 4))
                                : MODE_W'($urandom_range(0, 7));
            write_reg(REG_MODE, {hi[CFG_DATA_W-1:MODE_W], mode_code});
            if ($urandom_range(0, 1) == 1) begin
                hi = $urandom;
                r = $urandom_range(0, 9);
                if (r == 0) amp = '0;
                else if (r == 1) amp = '1;
                else amp = AMP_W'($urandom_range(0, 255));
                write_reg(REG_AMPLITUDE, {hi[CFG_DATA_W-1:AMP_W], amp});
            end
            if ($urandom_range(0, 1) == 1) write_reg(REG_RAMP_PERIOD, rand_time());
            if ($urandom_range(0, 1) == 1) write_reg(REG_HIGH_TIME, rand_time());
            if ($urandom_range(0, 1) == 1) write_reg(REG_LOW_TIME, rand_time());
            if ($urandom_range(0, 1) == 1) begin
                r = $urandom_range(0, 9);
                if (r == 0) step = '0;
                else if (r == 1) step = '1;
                else if (r < 6) step = $urandom;
                else step = $urandom_range(1, 32'h0100_0000);
                write_reg(REG_PHASE_STEP, step);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            n = $urandom_range(5, 60);
            repeat (n) begin
                send_tick($urandom_range(0, 15) == 0);
                random_ticks++;
            end
        end

        steady = 1'b0;
        settle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> pwm_pattern_generator.f
hdl/pwmpg_pkg.sv
hdl/pwmpg_cfg_regs.sv
hdl/pwmpg_sine_rom.sv
hdl/pwmpg_datapath.sv
hdl/pwmpg_ctrl.sv
hdl/pwm_pattern_generator.sv
tb/tb_pwm_pattern_generator.sv
